/* design/sprite_anim_frame_select_top_macros.svh */
// ----------------------------------------------------------------------------
// sprite animation frame select: assertion macros
// concurrent check wrappers clocked on clk, held off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef SPRITE_ANIM_FRAME_SELECT_TOP_MACROS_SVH
`define SPRITE_ANIM_FRAME_SELECT_TOP_MACROS_SVH

// same-cycle implication
`define SAFS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SAFS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/safs_pkg.sv */
// ----------------------------------------------------------------------------
// safs_pkg
// shared widths, codes and types of the sprite animation frame selector
// ----------------------------------------------------------------------------
package safs_pkg;

  // parameter defaults
  localparam int MAX_CELS_DEF   = 64;
  localparam int MAX_FRAMES_DEF = 128;
  localparam int DELAY_BITS_DEF = 16;

  // fixed field widths
  localparam int OP_W      = 2;
  localparam int FIDX_W    = 7;
  localparam int TIME_W    = 31;
  localparam int CEL_W     = 6;
  localparam int TOTAL_W   = 23;
  localparam int MODE_W    = 2;
  localparam int CCNT_W    = 7;
  localparam int CREG_W    = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // operations
  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_FINAL = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  // animation modes
  localparam logic [MODE_W-1:0] MODE_LOOP     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ONCE     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PINGPONG = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ANIM_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CEL_COUNT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_DELAY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BEGIN_TIME  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_END_TIME    = 3'd4;

  // control of the delay ring
  typedef struct packed {
    logic shift;
    logic wr_en;
  } ring_ctl_t;

  function automatic int imax(int a, int b);
    return (a > b) ? a : b;
  endfunction

endpackage

/* design/safs_cell.sv */
// ----------------------------------------------------------------------------
// safs_cell
// one delay entry of the ring: loads from its neighbor or from a write
// ----------------------------------------------------------------------------
module safs_cell #(
  parameter int WIDTH = safs_pkg::DELAY_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             shift,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [WIDTH-1:0] nb_in,
  output logic [WIDTH-1:0] data_out
);

  logic [WIDTH-1:0] data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r <= '0;
    end else if (shift) begin
      data_r <= nb_in;
    end else if (wr_en) begin
      data_r <= wr_data;
    end
  end

  assign data_out = data_r;

endmodule

/* design/safs_ring.sv */
// ----------------------------------------------------------------------------
// safs_ring
// circular chain of delay cells; shifts toward cell 0, tail refilled by caller
// ----------------------------------------------------------------------------
module safs_ring #(
  parameter int DEPTH = safs_pkg::MAX_FRAMES_DEF,
  parameter int WIDTH = safs_pkg::DELAY_BITS_DEF,
  localparam int IDX_W = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  safs_pkg::ring_ctl_t ctl,
  input  logic [IDX_W-1:0]    wr_idx,
  input  logic [WIDTH-1:0]    wr_data,
  input  logic [WIDTH-1:0]    tail_in,
  output logic [WIDTH-1:0]    head
);

  logic [WIDTH-1:0] q [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WIDTH-1:0] nb;
    logic             cell_wr;

    if (i == DEPTH - 1) begin : g_tail
      assign nb = tail_in;
    end else begin : g_mid
      assign nb = q[i+1];
    end

    assign cell_wr = ctl.wr_en && (wr_idx == IDX_W'(i));

    safs_cell #(
      .WIDTH(WIDTH)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .shift   (ctl.shift),
      .wr_en   (cell_wr),
      .wr_data (wr_data),
      .nb_in   (nb),
      .data_out(q[i])
    );
  end

  assign head = q[0];

endmodule

/* design/safs_div.sv */
// ----------------------------------------------------------------------------
// safs_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module safs_div #(
  parameter int NUM_W = safs_pkg::TIME_W,
  parameter int DEN_W = safs_pkg::TOTAL_W,
  localparam int CNT_W = $clog2(NUM_W)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [NUM_W-1:0] quotient,
  output logic [DEN_W-1:0] remainder
);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign rem_sh = {rem_r, quo_r[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den_r};
  assign diff   = rem_sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[NUM_W-2:0], ge};
      rem_r <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

/* design/sprite_anim_frame_select_top.sv */
// ----------------------------------------------------------------------------
// sprite_anim_frame_select_top
// maps elapsed time to a sprite animation cel through a ring of delay cells
// ----------------------------------------------------------------------------
// usage:
//   in_* channel carries one op per transfer: write delay, finalize, query.
//   out_* channel returns exactly one result per op (cel, total, ready flag).
//   both use valid/stall; an op is taken when in_valid is high and in_stall low.
//   cfg_* is a plain write port; the user must write it only while no op is in flight (unchecked).
// op sequencing (one op at a time, the next op is taken as soon as this one is done):
//   write delay     : one ring write, then the result
//   finalize        : multiply with default timing, a full ring turn with the table
//   query, table    : modulo on the divider, then a full ring turn
//   query, default  : modulo, divide, modulo, all on the one divider
//   the ring always makes a full turn so every entry ends in its home cell.
// reset (synchronous, rst_n low): table cleared, not finalized, registers at
//   their defaults, output channel empty.
// a stalled result stays in the output register; a following op is still
//   accepted and runs, and only its result transfer waits for the register.
// ----------------------------------------------------------------------------
`include "sprite_anim_frame_select_top_macros.svh"

module sprite_anim_frame_select_top #(
  parameter int MAX_CELS   = safs_pkg::MAX_CELS_DEF,
  parameter int MAX_FRAMES = safs_pkg::MAX_FRAMES_DEF,
  parameter int DELAY_BITS = safs_pkg::DELAY_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration writes
  input  logic                           cfg_wr_en,
  input  logic [safs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [safs_pkg::CREG_W-1:0]    cfg_wdata,
  // op channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [safs_pkg::OP_W-1:0]      in_op,
  input  logic [safs_pkg::FIDX_W-1:0]    in_frame_index,
  input  logic [safs_pkg::TIME_W-1:0]    in_time_value,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [safs_pkg::CEL_W-1:0]     out_cel,
  output logic [safs_pkg::TOTAL_W-1:0]   out_total_time,
  output logic                           out_ready_res
);

  localparam int TIME_W   = safs_pkg::TIME_W;
  localparam int TOTAL_W  = safs_pkg::TOTAL_W;
  localparam int RI_W     = $clog2(MAX_FRAMES);
  localparam int FC_W     = $clog2(MAX_FRAMES + 1);
  localparam int CN_W     = safs_pkg::imax(safs_pkg::CCNT_W, $clog2(MAX_CELS + 1));
  localparam int FR_W     = safs_pkg::imax(CN_W + 1, FC_W);
  localparam int FI_CMP_W = safs_pkg::imax(safs_pkg::FIDX_W, FC_W);
  localparam int CMP_W    = safs_pkg::imax(TIME_W, DELAY_BITS);
  localparam int ACC_W    = safs_pkg::imax(TOTAL_W, DELAY_BITS) + 1;
  localparam int MUL_W    = safs_pkg::imax(DELAY_BITS + FC_W, TOTAL_W + 1);
  localparam int DVS_W    = safs_pkg::imax(safs_pkg::imax(TOTAL_W, DELAY_BITS), FC_W);

  // sequencer states
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_FIN_WALK = 4'd1;
  localparam logic [3:0] S_FIN_END  = 4'd2;
  localparam logic [3:0] S_FIN_MUL  = 4'd3;
  localparam logic [3:0] S_MOD      = 4'd4;
  localparam logic [3:0] S_SEL      = 4'd5;
  localparam logic [3:0] S_WALK     = 4'd6;
  localparam logic [3:0] S_DIVD     = 4'd7;
  localparam logic [3:0] S_DIVF     = 4'd8;
  localparam logic [3:0] S_MAP      = 4'd9;
  localparam logic [3:0] S_OUT      = 4'd10;

  // configuration registers
  logic [safs_pkg::MODE_W-1:0] anim_mode_r;
  logic [safs_pkg::CCNT_W-1:0] cel_count_r;
  logic [safs_pkg::CREG_W-1:0] frame_delay_r;
  logic [safs_pkg::CREG_W-1:0] begin_time_r;
  logic [safs_pkg::CREG_W-1:0] end_time_r;

  // control state
  logic [3:0]         state_r, state_nxt;
  logic               pfu_r, pfu_nxt;
  logic [FC_W-1:0]    fc_r, fc_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic               mirror_r, mirror_nxt;
  logic               fin_r, fin_nxt;
  logic [RI_W-1:0]    idx_r, idx_nxt;
  logic               out_valid_r, out_valid_nxt;

  // working registers
  logic [TIME_W-1:0]          t_r, t_nxt;
  logic                       found_r, found_nxt;
  logic [FC_W-1:0]            frame_r, frame_nxt;
  logic [TOTAL_W-1:0]         acc_r, acc_nxt;
  logic [FC_W-1:0]            cel_r, cel_nxt;
  logic [safs_pkg::CEL_W-1:0] out_cel_r, out_cel_nxt;
  logic [TOTAL_W-1:0]         out_total_r, out_total_nxt;
  logic                       out_ready_r, out_ready_nxt;

  // derived values
  logic                  in_xfer;
  logic [DELAY_BITS-1:0] dflt, fdel_d, begin_d, end_d;
  logic                  begin_nz, end_nz;
  logic [CN_W-1:0]       n_raw, n_eff;
  logic                  mirror_calc;
  logic [FR_W-1:0]       fc_raw;
  logic [FC_W-1:0]       fc_calc;
  logic                  wr_in_range;
  logic                  once_hold;
  logic [FC_W-1:0]       frame_last;

  // ring walk
  safs_pkg::ring_ctl_t   ring_ctl;
  logic [DELAY_BITS-1:0] head, tail_in, fin_v;
  logic                  in_fc, walk_last;
  logic [CMP_W-1:0]      t_ext, h_ext;
  logic [ACC_W-1:0]      acc_sum;
  logic [TOTAL_W-1:0]    acc_sat;

  // default timing total
  logic [MUL_W-1:0]   prod;
  logic [TOTAL_W-1:0] prod_sat;

  // ping-pong fold
  logic [FC_W-1:0] fold_n, fold_top, mapped;

  // shared divider
  logic              div_start, div_done;
  logic [TIME_W-1:0] div_dividend, div_quo;
  logic [DVS_W-1:0]  div_divisor, div_rem;

  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;

  // register values, masked to the delay width
  assign fdel_d   = DELAY_BITS'(frame_delay_r);
  assign dflt     = (fdel_d == '0) ? DELAY_BITS'(1) : fdel_d;
  assign begin_d  = DELAY_BITS'(begin_time_r);
  assign end_d    = DELAY_BITS'(end_time_r);
  assign begin_nz = (begin_d != '0);
  assign end_nz   = (end_d != '0);

  // frame count for finalize: cel count clamped, doubled back in ping-pong
  assign n_raw = CN_W'(cel_count_r);
  always_comb begin
    if (n_raw == '0) begin
      n_eff = CN_W'(1);
    end else if (n_raw > CN_W'(MAX_CELS)) begin
      n_eff = CN_W'(MAX_CELS);
    end else begin
      n_eff = n_raw;
    end
  end
  assign mirror_calc = (anim_mode_r == safs_pkg::MODE_PINGPONG) && (n_eff > CN_W'(1));
  assign fc_raw  = mirror_calc ? (FR_W'({n_eff, 1'b0}) - FR_W'(2)) : FR_W'(n_eff);
  assign fc_calc = (fc_raw > FR_W'(MAX_FRAMES)) ? FC_W'(MAX_FRAMES) : FC_W'(fc_raw);

  assign wr_in_range = FI_CMP_W'(in_frame_index) < FI_CMP_W'(MAX_FRAMES);
  assign once_hold   = (anim_mode_r == safs_pkg::MODE_ONCE) &&
                       (in_time_value >= TIME_W'(total_r));
  assign frame_last  = fc_r - FC_W'(1);

  // entry at the ring head has index idx_r
  assign in_fc     = FC_W'(idx_r) < fc_r;
  assign walk_last = (idx_r == RI_W'(MAX_FRAMES - 1));
  assign t_ext     = CMP_W'(t_r);
  assign h_ext     = CMP_W'(head);

  // finalize pass: begin/end override, zero entries take the default, clear past the frame count
  always_comb begin
    fin_v = head;
    if ((idx_r == '0) && begin_nz) begin
      fin_v = begin_d;
    end
    if ((FC_W'(idx_r) == frame_last) && end_nz) begin
      fin_v = end_d;
    end
    if (!in_fc) begin
      fin_v = '0;
    end else if (fin_v == '0) begin
      fin_v = dflt;
    end
  end

  assign acc_sum = ACC_W'(acc_r) + ACC_W'(fin_v);
  assign acc_sat = (acc_sum > ACC_W'(safs_pkg::TOTAL_MAX)) ? safs_pkg::TOTAL_MAX
                                                           : TOTAL_W'(acc_sum);

  assign prod     = MUL_W'(dflt) * MUL_W'(fc_r);
  assign prod_sat = (prod > MUL_W'(safs_pkg::TOTAL_MAX)) ? safs_pkg::TOTAL_MAX
                                                         : TOTAL_W'(prod);

  // ping-pong: frames at or past n run back down
  assign fold_n   = (fc_r >> 1) + FC_W'(1);
  assign fold_top = {fc_r[FC_W-1:1], 1'b0};
  assign mapped   = (mirror_r && (frame_r >= fold_n)) ? (fold_top - frame_r) : frame_r;

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    pfu_nxt        = pfu_r;
    fc_nxt         = fc_r;
    total_nxt      = total_r;
    mirror_nxt     = mirror_r;
    fin_nxt        = fin_r;
    idx_nxt        = idx_r;
    t_nxt          = t_r;
    found_nxt      = found_r;
    frame_nxt      = frame_r;
    acc_nxt        = acc_r;
    cel_nxt        = cel_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_cel_nxt    = out_cel_r;
    out_total_nxt  = out_total_r;
    out_ready_nxt  = out_ready_r;
    ring_ctl.shift = 1'b0;
    ring_ctl.wr_en = 1'b0;
    tail_in        = head;
    div_start      = 1'b0;
    div_dividend   = t_r;
    div_divisor    = DVS_W'(total_r);

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          cel_nxt   = '0;
          state_nxt = S_OUT;
          unique case (in_op)
            safs_pkg::OP_WRITE: begin
              if (wr_in_range) begin
                ring_ctl.wr_en = 1'b1;
                pfu_nxt        = 1'b1;
              end
            end
            safs_pkg::OP_FINAL: begin
              fc_nxt     = fc_calc;
              mirror_nxt = mirror_calc;
              pfu_nxt    = pfu_r || begin_nz || end_nz;
              idx_nxt    = '0;
              acc_nxt    = '0;
              state_nxt  = (pfu_r || begin_nz || end_nz) ? S_FIN_WALK : S_FIN_MUL;
            end
            safs_pkg::OP_QUERY: begin
              if (fin_r) begin
                t_nxt = in_time_value;
                if (once_hold) begin
                  frame_nxt = frame_last;
                  state_nxt = S_MAP;
                end else if (total_r != '0) begin
                  div_start    = 1'b1;
                  div_dividend = in_time_value;
                  div_divisor  = DVS_W'(total_r);
                  state_nxt    = S_MOD;
                end else begin
                  state_nxt = S_SEL;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_FIN_WALK: begin
        ring_ctl.shift = 1'b1;
        tail_in        = fin_v;
        acc_nxt        = acc_sat;
        idx_nxt        = idx_r + RI_W'(1);
        if (walk_last) begin
          idx_nxt   = '0;
          state_nxt = S_FIN_END;
        end
      end
      S_FIN_END: begin
        total_nxt = acc_r;
        fin_nxt   = 1'b1;
        state_nxt = S_OUT;
      end
      S_FIN_MUL: begin
        total_nxt = prod_sat;
        fin_nxt   = 1'b1;
        state_nxt = S_OUT;
      end
      S_MOD: begin
        if (div_done) begin
          t_nxt     = TIME_W'(div_rem);
          state_nxt = S_SEL;
        end
      end
      S_SEL: begin
        if (pfu_r) begin
          idx_nxt   = '0;
          found_nxt = 1'b0;
          frame_nxt = frame_last;
          state_nxt = S_WALK;
        end else begin
          div_start    = 1'b1;
          div_dividend = t_r;
          div_divisor  = DVS_W'(dflt);
          state_nxt    = S_DIVD;
        end
      end
      S_WALK: begin
        ring_ctl.shift = 1'b1;
        if (!found_r && in_fc) begin
          if (t_ext < h_ext) begin
            found_nxt = 1'b1;
            frame_nxt = FC_W'(idx_r);
          end else begin
            t_nxt = TIME_W'(t_ext - h_ext);
          end
        end
        idx_nxt = idx_r + RI_W'(1);
        if (walk_last) begin
          idx_nxt   = '0;
          state_nxt = S_MAP;
        end
      end
      S_DIVD: begin
        if (div_done) begin
          div_start    = 1'b1;
          div_dividend = div_quo;
          div_divisor  = DVS_W'(fc_r);
          state_nxt    = S_DIVF;
        end
      end
      S_DIVF: begin
        if (div_done) begin
          frame_nxt = FC_W'(div_rem);
          state_nxt = S_MAP;
        end
      end
      S_MAP: begin
        cel_nxt   = mapped;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_cel_nxt   = safs_pkg::CEL_W'(cel_r);
          out_total_nxt = total_r;
          out_ready_nxt = fin_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      pfu_r         <= 1'b0;
      fc_r          <= FC_W'(1);
      total_r       <= '0;
      mirror_r      <= 1'b0;
      fin_r         <= 1'b0;
      idx_r         <= '0;
      out_valid_r   <= 1'b0;
      anim_mode_r   <= safs_pkg::MODE_LOOP;
      cel_count_r   <= safs_pkg::CCNT_W'(1);
      frame_delay_r <= safs_pkg::CREG_W'(1);
      begin_time_r  <= '0;
      end_time_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      pfu_r       <= pfu_nxt;
      fc_r        <= fc_nxt;
      total_r     <= total_nxt;
      mirror_r    <= mirror_nxt;
      fin_r       <= fin_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          safs_pkg::REG_ANIM_MODE:   anim_mode_r   <= cfg_wdata[safs_pkg::MODE_W-1:0];
          safs_pkg::REG_CEL_COUNT:   cel_count_r   <= cfg_wdata[safs_pkg::CCNT_W-1:0];
          safs_pkg::REG_FRAME_DELAY: frame_delay_r <= cfg_wdata;
          safs_pkg::REG_BEGIN_TIME:  begin_time_r  <= cfg_wdata;
          safs_pkg::REG_END_TIME:    end_time_r    <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  // working and output payload
  always_ff @(posedge clk) begin
    t_r         <= t_nxt;
    found_r     <= found_nxt;
    frame_r     <= frame_nxt;
    acc_r       <= acc_nxt;
    cel_r       <= cel_nxt;
    out_cel_r   <= out_cel_nxt;
    out_total_r <= out_total_nxt;
    out_ready_r <= out_ready_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_cel        = out_cel_r;
  assign out_total_time = out_total_r;
  assign out_ready_res  = out_ready_r;

  safs_ring #(
    .DEPTH(MAX_FRAMES),
    .WIDTH(DELAY_BITS)
  ) u_ring (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ring_ctl),
    .wr_idx (RI_W'(in_frame_index)),
    .wr_data(DELAY_BITS'(in_time_value)),
    .tail_in(tail_in),
    .head   (head)
  );

  safs_div #(
    .NUM_W(TIME_W),
    .DEN_W(DVS_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo),
    .remainder(div_rem)
  );

  // ring back in its home position whenever no op is running
  `SAFS_ASSERT_IMPL(a_ring_aligned, state_r == S_IDLE, idx_r == '0, "ring not realigned at idle")
  // divider results arrive only while the sequencer waits for them
  `SAFS_ASSERT_IMPL(a_div_done_wait, div_done, (state_r == S_MOD || state_r == S_DIVD || state_r == S_DIVF), "divider done outside a wait state")
  // selected frame lies inside the frame count
  `SAFS_ASSERT_IMPL(a_frame_range, state_r == S_MAP, frame_r < fc_r, "frame past frame count")
  // finalize always leaves the block ready
  `SAFS_ASSERT_NEXT(a_fin_ready, (state_r == S_FIN_END || state_r == S_FIN_MUL), fin_r, "finalize did not set ready")

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: sprite animation frame select
// drives delay writes, finalizes and time queries into the frame selector,
// predicts results with an in-bench model of the cel selection (directed rows
// may type theirs) and checks cel, total time and ready flag of each transfer
// ----------------------------------------------------------------------------
module tb_top;
  import safs_pkg::*;

  // codes that the package leaves unnamed
  localparam logic [OP_W-1:0]   OP_SPARE   = 2'd3;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  // run shape
  localparam int STALL_LIMIT     = 3000;  // cycles with no transfer or register write
  localparam int DEFAULT_ITEMS   = 350;   // items in default timing phases
  localparam int TOTAL_ITEMS     = 1450;
  localparam int SETTLE_CYCLES   = 200;   // longer than the slowest query
  localparam int FIRST_TABLE_ROW = 19;    // first directed row in table timing
  localparam int N_ROWS          = 33;

  typedef struct packed {
    logic [CEL_W-1:0]   cel;
    logic [TOTAL_W-1:0] total;
    logic               ready;
  } frame_result_t;

  typedef enum bit {ROW_OP, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CREG_W-1:0]     reg_val;
    logic [OP_W-1:0]       op;
    logic [FIDX_W-1:0]     idx;
    logic [TIME_W-1:0]     tv;
    logic                  typed;  // expectation given below instead of predicted
    frame_result_t         res;
  } dir_row_t;

  localparam frame_result_t NO_RES = '0;

  // clock, reset and dut inputs, all known from time zero
  logic                 clk            = 1'b0;
  logic                 rst_n          = 1'b0;
  logic                 cfg_wr_en      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index      = '0;
  logic [CREG_W-1:0]    cfg_wdata      = '0;
  logic                 in_valid       = 1'b0;
  logic [OP_W-1:0]      in_op          = '0;
  logic [FIDX_W-1:0]    in_frame_index = '0;
  logic [TIME_W-1:0]    in_time_value  = '0;
  logic                 out_stall      = 1'b0;
  logic                 in_stall;
  logic                 out_valid;
  logic [CEL_W-1:0]     out_cel;
  logic [TOTAL_W-1:0]   out_total_time;
  logic                 out_ready_res;

  always #6 clk = ~clk;

  sprite_anim_frame_select_top DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_frame_index (in_frame_index),
    .in_time_value  (in_time_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_cel        (out_cel),
    .out_total_time (out_total_time),
    .out_ready_res  (out_ready_res)
  );

  // --------------------------------------------------------------------------
  // animation model: registers and state as the block holds them
  // --------------------------------------------------------------------------
  logic [MODE_W-1:0]  r_mode  = MODE_LOOP;
  logic [CCNT_W-1:0]  r_cels  = 7'd1;
  logic [CREG_W-1:0]  r_delay = 16'd1;
  logic [CREG_W-1:0]  r_begin = '0;
  logic [CREG_W-1:0]  r_end   = '0;

  logic [CREG_W-1:0]  delay_tbl [MAX_FRAMES_DEF];
  bit                 table_timing = 1'b0;  // sticky until reset
  int unsigned        n_frames     = 1;
  logic [TOTAL_W-1:0] total_acc    = '0;
  bit                 mirrored     = 1'b0;
  bit                 done_final   = 1'b0;

  // results owed by the block, oldest first
  frame_result_t frame_results_due [$];

  // bookkeeping
  int  errors = 0;
  int  n_checked = 0;
  int  ops_sent = 0;  // spare-op transfers not counted
  int  n_query = 0, n_final = 0, n_write = 0, n_spare = 0;
  bit  no_idle = 1'b0;
  int  quiet_cycles = 0;

  initial begin
    for (int i = 0; i < MAX_FRAMES_DEF; i++) delay_tbl[i] = '0;
  end

  function automatic int unsigned cels_eff();
    int unsigned n;
    n = r_cels;
    if (n == 0) n = 1;
    if (n > MAX_CELS_DEF) n = MAX_CELS_DEF;
    return n;
  endfunction

  function automatic int unsigned delay_eff();
    return (r_delay == '0) ? 1 : int'(r_delay);
  endfunction

  // frame count that a finalize would set with the current registers
  function automatic int unsigned frames_planned();
    int unsigned n, c;
    n = cels_eff();
    c = (r_mode == MODE_PINGPONG && n > 1) ? 2 * n - 2 : n;
    if (c > MAX_FRAMES_DEF) c = MAX_FRAMES_DEF;
    return c;
  endfunction

  // ping-pong runs forward then back over the same cels
  function automatic int unsigned fold_frame(int unsigned f);
    int unsigned h;
    if (!mirrored) return f;
    h = n_frames / 2 + 1;
    return (f < h) ? f : 2 * h - 2 - f;
  endfunction

  function automatic void finalize_anim();
    longint unsigned sum;
    int unsigned     dflt;
    dflt     = delay_eff();
    mirrored = (r_mode == MODE_PINGPONG) && (cels_eff() > 1);
    n_frames = frames_planned();
    if (r_begin != '0) begin
      delay_tbl[0] = r_begin;
      table_timing = 1'b1;
    end
    if (r_end != '0) begin
      delay_tbl[n_frames - 1] = r_end;
      table_timing = 1'b1;
    end
    sum = 0;
    if (table_timing) begin
      // entries past the frame count are cleared, holes take the default
      for (int i = 0; i < MAX_FRAMES_DEF; i++) begin
        if (i >= n_frames) begin
          delay_tbl[i] = '0;
        end else begin
          if (delay_tbl[i] == '0) delay_tbl[i] = CREG_W'(dflt);
          sum += delay_tbl[i];
        end
      end
    end else begin
      sum = longint'(dflt) * n_frames;
    end
    total_acc  = (sum > TOTAL_MAX) ? TOTAL_MAX : TOTAL_W'(sum);
    done_final = 1'b1;
  endfunction

  function automatic int unsigned select_cel(int unsigned t);
    int unsigned f;
    // play once holds the last cel at and past the end
    if (r_mode == MODE_ONCE && t >= total_acc) return fold_frame(n_frames - 1);
    if (total_acc != '0) t = t % total_acc;
    if (table_timing) begin
      f = n_frames - 1;  // walk that runs off the end keeps the last frame
      for (int i = 0; i < n_frames; i++) begin
        if (t < delay_tbl[i]) begin
          f = i;
          break;
        end
        t -= delay_tbl[i];
      end
    end else begin
      f = (t / delay_eff()) % n_frames;
    end
    return fold_frame(f);
  endfunction

  function automatic frame_result_t predict_frame_result(logic [OP_W-1:0] op,
                                                         logic [FIDX_W-1:0] idx,
                                                         logic [TIME_W-1:0] tv);
    frame_result_t r;
    r = '0;
    case (op)
      OP_WRITE: begin
        delay_tbl[idx] = tv[CREG_W-1:0];
        table_timing   = 1'b1;
      end
      OP_FINAL: finalize_anim();
      OP_QUERY: if (done_final) r.cel = CEL_W'(select_cel(tv));
      default: ;
    endcase
    r.total = total_acc;
    r.ready = done_final;
    return r;
  endfunction

  function automatic void model_reg_write(logic [CFG_IDX_W-1:0] idx, logic [CREG_W-1:0] val);
    case (idx)
      REG_ANIM_MODE:   r_mode  = val[MODE_W-1:0];
      REG_CEL_COUNT:   r_cels  = val[CCNT_W-1:0];
      REG_FRAME_DELAY: r_delay = val;
      REG_BEGIN_TIME:  r_begin = val;
      REG_END_TIME:    r_end   = val;
      default: ;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // random draws
  // --------------------------------------------------------------------------
  function automatic int unsigned draw_wait();
    return no_idle ? 0 : $urandom_range(0, 18);
  endfunction

  function automatic logic [CREG_W-1:0] pick_delay();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return CREG_W'($urandom);
      default: return CREG_W'($urandom_range(1, 60));
    endcase
  endfunction

  // times near and around the loop length, plus the extremes
  function automatic logic [TIME_W-1:0] pick_time();
    int unsigned tot;
    tot = total_acc;
    case ($urandom_range(0, 9))
      0:       return TIME_W'($urandom);
      1:       return '1;
      2:       return '0;
      3:       return TIME_W'(tot + $urandom_range(0, 2) - 1);
      default: return TIME_W'($urandom_range(0, 2 * tot + 1));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // op channel
  // --------------------------------------------------------------------------
  // valid stays high after a transfer; a zero gap only swaps the payload
  task automatic send_op(input logic [OP_W-1:0] op, input logic [FIDX_W-1:0] idx,
                         input logic [TIME_W-1:0] tv, input logic typed,
                         input frame_result_t typed_res);
    int unsigned   gap;
    frame_result_t pred;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_op          <= op;
    in_frame_index <= idx;
    in_time_value  <= tv;
    do @(posedge clk); while (in_stall !== 1'b0);
    // transfer taken at this edge
    pred = predict_frame_result(op, idx, tv);
    frame_results_due.push_back(typed ? typed_res : pred);
    case (op)
      OP_WRITE: n_write++;
      OP_FINAL: n_final++;
      OP_QUERY: n_query++;
      default:  n_spare++;
    endcase
    if (op != OP_SPARE) ops_sent++;
  endtask

  // let every owed result come out, so registers change only while idle
  task automatic drain();
    in_valid <= 1'b0;
    while (frame_results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CREG_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    model_reg_write(idx, val);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // one setting of the registers, then an optional table load, a finalize
  // (most times) and a run of queries with some noise mixed in
  task automatic run_phase(input bit table_phase);
    logic [MODE_W-1:0] mode;
    logic [CCNT_W-1:0] cels;
    logic [CREG_W-1:0] dly, bt, et;
    int unsigned       planned, writes, len, pick;
    mode = MODE_W'($urandom_range(0, 3));
    case ($urandom_range(0, 9))
      0:       cels = '0;
      1:       cels = '1;
      2:       cels = CCNT_W'(MAX_CELS_DEF);
      3:       cels = CCNT_W'($urandom_range(MAX_CELS_DEF + 1, 126));
      default: cels = CCNT_W'($urandom_range(1, 16));
    endcase
    case ($urandom_range(0, 9))
      0:       dly = '0;
      1:       dly = '1;
      2:       dly = CREG_W'($urandom);
      default: dly = CREG_W'($urandom_range(1, 40));
    endcase
    // begin and end delays switch to table timing, so only in table phases
    bt = (table_phase && $urandom_range(0, 2) != 0) ? pick_delay() : '0;
    et = (table_phase && $urandom_range(0, 2) != 0) ? pick_delay() : '0;
    drain();
    write_reg(REG_ANIM_MODE, CREG_W'(mode));
    write_reg(REG_CEL_COUNT, CREG_W'(cels));
    write_reg(REG_FRAME_DELAY, dly);
    write_reg(REG_BEGIN_TIME, bt);
    write_reg(REG_END_TIME, et);
    no_idle = ($urandom_range(0, 4) == 0);
    if (table_phase) begin
      planned = frames_planned();
      writes  = $urandom_range(0, (planned < 24) ? planned : 24);
      repeat (writes) begin
        send_op(OP_WRITE,
                ($urandom_range(0, 7) == 0) ? FIDX_W'($urandom_range(0, 127))
                                            : FIDX_W'($urandom_range(0, planned - 1)),
                {15'($urandom), pick_delay()}, 1'b0, NO_RES);
      end
    end
    // now and then the queries run against the previous finalize
    if ($urandom_range(0, 7) != 0)
      send_op(OP_FINAL, FIDX_W'($urandom), TIME_W'($urandom), 1'b0, NO_RES);
    len = $urandom_range(8, 30);
    repeat (len) begin
      pick = $urandom_range(0, 99);
      if (pick < 4)
        send_op(OP_SPARE, FIDX_W'($urandom), TIME_W'($urandom), 1'b0, NO_RES);
      else if (table_phase && pick < 10)
        send_op(OP_WRITE, FIDX_W'($urandom), {15'($urandom), pick_delay()}, 1'b0, NO_RES);
      else
        send_op(OP_QUERY, FIDX_W'($urandom), pick_time(), 1'b0, NO_RES);
    end
  endtask

  // --------------------------------------------------------------------------
  // directed rows: reset state, default timing extremes, then table timing
  // --------------------------------------------------------------------------
  dir_row_t directed_rows [0:N_ROWS-1] = '{
    // query and spare op before any finalize give nothing ready
    '{ROW_OP,  REG_ANIM_MODE,   16'h0000, OP_QUERY, 7'd0,   31'h0000_0000, 1'b1,
      '{6'd0, 23'd0, 1'b0}},
    '{ROW_OP,  REG_ANIM_MODE,   16'h0000, OP_QUERY, 7'd0,   31'h7FFF_FFFF, 1'b1,
      '{6'd0, 23'd0, 1'b0}},
    '{ROW_OP,  REG_ANIM_MODE,   16'h0000, OP_SPARE, 7'd127, 31'h7FFF_FFFF, 1'b1,
      '{6'd0, 23'd0, 1'b0}},
    // reset registers: one cel, one tick
    '{ROW_OP,  REG_ANIM_MODE,   16'h0000, OP_FINAL, 7'd0,   31'h0000_0000, 1'b1,
      '{6'd0, 23'd1, 1'b1}},
    '{ROW_OP,  REG_ANIM_MODE,   16'h0000, OP_QUERY, 7'd0,   31'h7FFF_FFFF, 1'b1,
      '{6'd0, 23'd1, 1'b1}},
    // too many cels clamp to the maximum, zero delay counts as one
    '{ROW_REG, REG_CEL_COUNT,   16'd127,  OP_SPARE, 7'd0,   31'h0000_0000, 1'b0, '0},
    '{ROW_REG, REG_FRAME_DELAY, 16'h0000, OP_SPARE, 7'd0,   31'h0000_0000, 1'b0, '0},
    '{ROW_OP,  REG_ANIM_MODE,   16'h0000, OP_FINAL, 7'd0,   31'h0000_0000, 1'b1,
      '{6'd0, 23'd64, 1'b1}},
    '{ROW_OP,  REG_ANIM_MODE,   16'h0000, OP_QUERY, 7'd0,   31'h7FFF_FFFF, 1'b1,
      '{6'd63, 23'd64, 1'b1}},
    '{ROW_OP,  REG_ANIM_MODE,   16'h0000, OP_QUERY, 7'd0,   31'h0000_0000, 1'b1,
      '{6'd0, 23'd64, 1'b1}},
    // ping-pong with the longest default delay
    '{ROW_REG, REG_ANIM_MODE,   16'(MODE_PINGPONG), OP_SPARE, 7'd0, 31'h0, 1'b0, '0},
    '{ROW_REG, REG_FRAME_DELAY, 16'hFFFF, OP_SPARE, 7'd0,   31'h0000_0000, 1'b0, '0},
    '{ROW_OP,  REG_ANIM_MODE,   16'h0000, OP_FINAL, 7'd0,   31'h0000_0000, 1'b0, '0},
    '{ROW_OP,  REG_ANIM_MODE,   16'h0000, OP_QUERY, 7'd0,   31'h7FFF_FFFF, 1'b0, '0},
    '{ROW_OP,  REG_ANIM_MODE,   16'h0000, OP_QUERY, 7'd0,   31'd4194240,   1'b0, '0},
    // mode is read at query time: play once holds, spare mode loops
    '{ROW_REG, REG_ANIM_MODE,   16'(MODE_ONCE), OP_SPARE, 7'd0, 31'h0, 1'b0, '0},
    '{ROW_OP,  REG_ANIM_MODE,   16'h0000, OP_QUERY, 7'd0,   31'h7FFF_FFFF, 1'b0, '0},
    '{ROW_REG, REG_ANIM_MODE,   16'(MODE_SPARE), OP_SPARE, 7'd0, 31'h0, 1'b0, '0},
    '{ROW_OP,  REG_ANIM_MODE,   16'h0000, OP_QUERY, 7'd0,   31'd12345678,  1'b0, '0},
    // table timing from here on
    '{ROW_REG, REG_ANIM_MODE,   16'(MODE_LOOP), OP_SPARE, 7'd0, 31'h0, 1'b0, '0},
    '{ROW_REG, REG_CEL_COUNT,   16'd4,    OP_SPARE, 7'd0,   31'h0000_0000, 1'b0, '0},
    '{ROW_REG, REG_FRAME_DELAY, 16'd10,   OP_SPARE, 7'd0,   31'h0000_0000, 1'b0, '0},
    '{ROW_REG, REG_BEGIN_TIME,  16'hFFFF, OP_SPARE, 7'd0,   31'h0000_0000, 1'b0, '0},
    '{ROW_REG, REG_END_TIME,    16'h0001, OP_SPARE, 7'd0,   31'h0000_0000, 1'b0, '0},
    // last entry gets cleared by finalize, a zero entry gets the default
    '{ROW_OP,  REG_ANIM_MODE,   16'h0000, OP_WRITE, 7'd127, 31'h7FFF_FFFF, 1'b0, '0},
    '{ROW_OP,  REG_ANIM_MODE,   16'h0000, OP_WRITE, 7'd1,   31'h0000_0000, 1'b0, '0},
    '{ROW_OP,  REG_ANIM_MODE,   16'h0000, OP_WRITE, 7'd2,   31'h4000_0005, 1'b0, '0},
    '{ROW_OP,  REG_ANIM_MODE,   16'h0000, OP_FINAL, 7'd0,   31'h0000_0000, 1'b0, '0},
    '{ROW_OP,  REG_ANIM_MODE,   16'h0000, OP_QUERY, 7'd0,   31'd65535,     1'b0, '0},
    '{ROW_OP,  REG_ANIM_MODE,   16'h0000, OP_QUERY, 7'd0,   31'd65550,     1'b0, '0},
    // zero entry written after finalize is walked as a zero delay
    '{ROW_OP,  REG_ANIM_MODE,   16'h0000, OP_WRITE, 7'd1,   31'h0000_0000, 1'b0, '0},
    '{ROW_OP,  REG_ANIM_MODE,   16'h0000, OP_QUERY, 7'd0,   31'd65535,     1'b0, '0},
    '{ROW_OP,  REG_ANIM_MODE,   16'h0000, OP_QUERY, 7'd0,   31'h7FFF_FFFF, 1'b0, '0}
  };

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < N_ROWS; r++) begin
      // table timing sticks until reset, so the default timing random
      // traffic has to go in before the first table row
      if (r == FIRST_TABLE_ROW) begin
        while (ops_sent < DEFAULT_ITEMS) run_phase(1'b0);
      end
      if (directed_rows[r].kind == ROW_REG) begin
        drain();
        write_reg(directed_rows[r].reg_idx, directed_rows[r].reg_val);
      end else begin
        send_op(directed_rows[r].op, directed_rows[r].idx, directed_rows[r].tv,
                directed_rows[r].typed, directed_rows[r].res);
      end
    end

    while (ops_sent < TOTAL_ITEMS) run_phase(1'b1);

    // wind down: everything owed, then a quiet stretch for strays
    in_valid <= 1'b0;
    while (frame_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("run covered %0d queries, %0d finalizes, %0d delay writes, %0d spare ops",
             n_query, n_final, n_write, n_spare);
    $display("%0d result transfers checked, %0d errors", n_checked, errors);
    if (errors == 0) begin
      $display("sprite_anim_frame_select_top: match");
    end else begin
      $display("sprite_anim_frame_select_top: mismatch");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // result channel: random stall per result, then check on transfer
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned   hold;
    frame_result_t want;
    wait (rst_n === 1'b1);
    forever begin
      hold = draw_wait();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      // stall is low from here, so valid at an edge means a transfer
      do @(posedge clk); while (out_valid !== 1'b1);
      if (frame_results_due.size() == 0) begin
        errors++;
        $display("%0t: result transfer with nothing outstanding (cel %0d total %0d ready %0d)",
                 $time, out_cel, out_total_time, out_ready_res);
      end else begin
        want = frame_results_due.pop_front();
        n_checked++;
        if (out_cel !== want.cel) begin
          errors++;
          $display("%0t: cel expected %0d got %0d", $time, want.cel, out_cel);
        end
        if (out_total_time !== want.total) begin
          errors++;
          $display("%0t: total_time expected %0d got %0d", $time, want.total, out_total_time);
        end
        if (out_ready_res !== want.ready) begin
          errors++;
          $display("%0t: ready expected %0d got %0d", $time, want.ready, out_ready_res);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: any transfer or register write counts as progress
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n || cfg_wr_en || (in_valid && in_stall === 1'b0) ||
        (out_valid === 1'b1 && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("sprite_anim_frame_select_top: mismatch");
      $finish;
    end
  end

endmodule

/* files.f */
+incdir+design
design/safs_pkg.sv
design/safs_cell.sv
design/safs_ring.sv
design/safs_div.sv
design/sprite_anim_frame_select_top.sv
test/tb_top.sv
